// ----- design/gqy_pkg.sv -----
// Shared types, constants and tables for the gyro quaternion yaw block.
package gqy_pkg;

    // Default CORDIC iteration count and its upper bound
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CORDIC_STEPS_MAX = 32;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // pi/90 in Q32: turns 1/16 deg/s times 2^24 s into a Q2.30 half angle
    localparam logic [27:0] RAD90_Q32 = 28'd149922641;

    // Heading scale: hundredths of a degree per turn
    localparam logic [15:0] CENTIDEG_TURN = 16'd36000;

    // Q2.30 one and the attitude reset value
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // Step time after reset (about 10 ms)
    localparam logic [23:0] STEP_TIME_RST = 24'd167772;

    // Configuration register indexes
    localparam logic [1:0] CFG_BIAS_X    = 2'd0;
    localparam logic [1:0] CFG_BIAS_Y    = 2'd1;
    localparam logic [1:0] CFG_BIAS_Z    = 2'd2;
    localparam logic [1:0] CFG_STEP_TIME = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_HALF,
        S_EULER,
        S_NORM,
        S_SQRT,
        S_DIV,
        S_YAW,
        S_CORDIC,
        S_HEAD,
        S_DONE
    } t_state;

    // One product term of the Euler step: target component, q index, h index, sign
    typedef struct packed {
        logic [1:0] comp;
        logic [1:0] qi;
        logic [1:0] hi;
        logic       neg;
    } t_term;

    // Terms of q' = q + H(h) q, three per component
    function automatic t_term euler_term(input logic [3:0] idx);
        t_term t;
        case (idx)
            4'd0:    t = '{comp: 2'd0, qi: 2'd1, hi: 2'd0, neg: 1'b1};
            4'd1:    t = '{comp: 2'd0, qi: 2'd2, hi: 2'd1, neg: 1'b1};
            4'd2:    t = '{comp: 2'd0, qi: 2'd3, hi: 2'd2, neg: 1'b1};
            4'd3:    t = '{comp: 2'd1, qi: 2'd0, hi: 2'd0, neg: 1'b0};
            4'd4:    t = '{comp: 2'd1, qi: 2'd2, hi: 2'd2, neg: 1'b0};
            4'd5:    t = '{comp: 2'd1, qi: 2'd3, hi: 2'd1, neg: 1'b1};
            4'd6:    t = '{comp: 2'd2, qi: 2'd0, hi: 2'd1, neg: 1'b0};
            4'd7:    t = '{comp: 2'd2, qi: 2'd1, hi: 2'd2, neg: 1'b1};
            4'd8:    t = '{comp: 2'd2, qi: 2'd3, hi: 2'd0, neg: 1'b0};
            4'd9:    t = '{comp: 2'd3, qi: 2'd0, hi: 2'd2, neg: 1'b0};
            4'd10:   t = '{comp: 2'd3, qi: 2'd1, hi: 2'd1, neg: 1'b0};
            4'd11:   t = '{comp: 2'd3, qi: 2'd2, hi: 2'd0, neg: 1'b1};
            default: t = '{comp: 2'd0, qi: 2'd0, hi: 2'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            5'd30:   a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- design/gqy_in_if.sv -----
// Input channel: three gyro rates with valid/ready handshake.
interface gqy_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

// ----- design/gqy_out_if.sv -----
// Output channel: heading and attitude quaternion with valid/ready handshake.
interface gqy_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] heading;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;

    modport source (output valid, output heading, output quat_w, output quat_x,
                    output quat_y, output quat_z, input ready);
    modport sink   (input valid, input heading, input quat_w, input quat_x,
                    input quat_y, input quat_z, output ready);
endinterface

// ----- design/gqy_mul.sv -----
// Shared signed multiplier with registered product.
module gqy_mul (
    input  logic                              i_clk,
    input  logic signed [gqy_pkg::MUL_W-1:0]  i_a,
    input  logic signed [gqy_pkg::MUL_W-1:0]  i_b,
    output logic signed [gqy_pkg::PROD_W-1:0] o_p
);

    logic signed [gqy_pkg::PROD_W-1:0] r_p;

    // Register every product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- design/gyro_quaternion_yaw.sv -----
// Top level: gyro rate integration into a quaternion and a heading.
//
// Input channel i_in carries rate_x, rate_y, rate_z (LSB 1/16 deg/s); an item
// is taken when valid and ready are both high. Output channel o_out returns one
// item per input: heading in 0.01 deg (negated yaw) and the new attitude
// quaternion in Q2.30. Bias and step time are to be written over the cfg port
// only while the block is idle; the block itself does not enforce this.
// One shared multiplier and a small sequencer do all the work. An accepted item
// passes through the half angles, the Euler step, the norm, the bit-serial
// square root, the restoring divisions that rescale the quaternion, the yaw
// arguments, the CORDIC iterations and the rounding and hand-off of the
// heading. A zero norm skips the divisions and resets the attitude to the
// identity. i_in.ready is high only while the sequencer idles, so a new item
// is not taken until the sequencer is through with the last one.
// The result sits in an output register; a new item is accepted while it
// waits, and a finished item stalls in the last state until the register frees.
// Reset (synchronous, active low) sets the attitude to the identity, the
// biases to zero and the step time to about 10 ms, and drops any pending item.
module gyro_quaternion_yaw #(
    parameter int CORDIC_STEPS = gqy_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gqy_in_if.sink      i_in,
    gqy_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    localparam int MW = gqy_pkg::MUL_W;
    localparam int PW = gqy_pkg::PROD_W;
    localparam logic [5:0] LAST_ROT = 6'(CORDIC_STEPS - 1);

    gqy_pkg::t_state r_state, n_state;

    logic [5:0]  r_cnt;
    logic [1:0]  r_axis;

    // Configuration
    logic signed [15:0] r_bias [3];
    logic [23:0]        r_step;

    // Working values
    logic signed [16:0] r_d   [3];
    logic signed [31:0] r_h   [3];
    logic signed [31:0] r_q   [4];
    logic signed [34:0] r_n   [4];
    logic [39:0]        r_mag;
    logic               r_neg;
    logic [51:0]        r_hic;
    logic [63:0]        r_sum;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [31:0]        r_s;
    logic [31:0]        r_rem;
    logic [30:0]        r_num;
    logic [30:0]        r_quo;
    logic               r_ovf;
    logic signed [63:0] r_accx;
    logic signed [63:0] r_accy;
    logic signed [35:0] r_cx;
    logic signed [35:0] r_cy;
    logic [31:0]        r_z;
    logic               r_zero;
    logic signed [15:0] r_hd;

    // Output register
    logic               r_o_valid;
    logic signed [15:0] r_o_head;
    logic signed [31:0] r_o_q [4];

    // Multiplier
    logic signed [MW-1:0] w_mul_a, w_mul_b;
    logic signed [PW-1:0] w_prod;

    gqy_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    logic w_out_free, w_load;
    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_load     = (r_state == gqy_pkg::S_DONE) && w_out_free;

    gqy_pkg::t_term w_term_iss, w_term_acc;
    assign w_term_iss = gqy_pkg::euler_term(r_cnt[3:0]);
    assign w_term_acc = gqy_pkg::euler_term(4'(r_cnt - 6'd1));

    // Half angle: combine hi and lo partial products, saturate, restore sign
    logic [36:0]        w_hm;
    logic [30:0]        w_hm_sat;
    logic signed [31:0] w_h;
    always_comb begin
        w_hm     = 37'(({1'b0, r_hic} + 53'(w_prod[43:16])) >> 16);
        w_hm_sat = (w_hm[36:31] != 6'd0) ? 31'h7FFF_FFFF : w_hm[30:0];
        w_h      = r_neg ? -$signed({1'b0, w_hm_sat}) : $signed({1'b0, w_hm_sat});
    end

    // Square root step
    logic [63:0] w_trial, w_res_next;
    logic        w_sq_ge;
    always_comb begin
        w_trial    = r_res + r_bit;
        w_sq_ge    = r_sum >= w_trial;
        w_res_next = w_sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    end

    // Division setup and step
    logic signed [34:0] w_nsel;
    logic [33:0]        w_nmag;
    logic [61:0]        w_dnum;
    logic [32:0]        w_dtry;
    logic               w_dge;
    logic [30:0]        w_fquo;
    logic [30:0]        w_qmag;
    logic signed [31:0] w_qval;
    always_comb begin
        w_nsel = r_n[r_axis];
        w_nmag = w_nsel[34] ? 34'(-w_nsel) : w_nsel[33:0];
        w_dnum = {w_nmag, 28'd0};
        w_dtry = {r_rem, r_num[30]};
        w_dge  = w_dtry >= {1'b0, r_s};
        w_fquo = {r_quo[29:0], w_dge};
        w_qmag = (r_ovf || (w_fquo > 31'h4000_0000)) ? 31'h4000_0000 : w_fquo;
        w_qval = w_nsel[34] ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});
    end

    // Yaw arguments (floored, sign kept) and CORDIC start
    logic signed [35:0] w_yx, w_yy;
    always_comb begin
        w_yx = 36'($signed(r_accx[63:30]));
        w_yy = 36'($signed(r_accy[63:29]));
    end

    // CORDIC rotation
    logic signed [35:0] w_xs, w_ys;
    logic [31:0]        w_atan;
    always_comb begin
        w_xs   = r_cx >>> r_cnt[4:0];
        w_ys   = r_cy >>> r_cnt[4:0];
        w_atan = gqy_pkg::atan_turn(r_cnt[4:0]);
    end

    // Heading rounding
    logic signed [32:0] w_ang;
    logic signed [PW-1:0] w_hsum;
    always_comb begin
        if (r_zero) begin
            w_ang = '0;
        end else if (r_z > 32'h8000_0000) begin
            w_ang = $signed({1'b1, r_z});
        end else begin
            w_ang = $signed({1'b0, r_z});
        end
        w_hsum = w_prod + (PW'(1) <<< 31);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gqy_pkg::S_IDLE:   if (i_in.valid) n_state = gqy_pkg::S_HALF;
            gqy_pkg::S_HALF:   if (r_cnt == 6'd4 && r_axis == 2'd2) n_state = gqy_pkg::S_EULER;
            gqy_pkg::S_EULER:  if (r_cnt == 6'd12) n_state = gqy_pkg::S_NORM;
            gqy_pkg::S_NORM:   if (r_cnt == 6'd4) n_state = gqy_pkg::S_SQRT;
            gqy_pkg::S_SQRT:   if (r_cnt == 6'd31) n_state = gqy_pkg::S_DIV;
            gqy_pkg::S_DIV: begin
                if (r_cnt == 6'd0 && r_axis == 2'd0 && r_s == 32'd0) begin
                    n_state = gqy_pkg::S_YAW;
                end else if (r_cnt == 6'd31 && r_axis == 2'd3) begin
                    n_state = gqy_pkg::S_YAW;
                end
            end
            gqy_pkg::S_YAW:    if (r_cnt == 6'd7) n_state = gqy_pkg::S_CORDIC;
            gqy_pkg::S_CORDIC: if (r_cnt == LAST_ROT) n_state = gqy_pkg::S_HEAD;
            gqy_pkg::S_HEAD:   if (r_cnt == 6'd1) n_state = gqy_pkg::S_DONE;
            gqy_pkg::S_DONE:   if (w_out_free) n_state = gqy_pkg::S_IDLE;
            default:           n_state = gqy_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshake and multiplier operands
    always_comb begin
        i_in.ready = (r_state == gqy_pkg::S_IDLE);
        w_mul_a    = '0;
        w_mul_b    = '0;
        case (r_state)
            gqy_pkg::S_HALF: begin
                case (r_cnt)
                    6'd0: begin
                        w_mul_a = MW'(r_d[r_axis]);
                        w_mul_b = $signed({{(MW-24){1'b0}}, r_step});
                    end
                    6'd2: begin
                        w_mul_a = $signed({{(MW-24){1'b0}}, r_mag[39:16]});
                        w_mul_b = $signed({{(MW-28){1'b0}}, gqy_pkg::RAD90_Q32});
                    end
                    6'd3: begin
                        w_mul_a = $signed({{(MW-16){1'b0}}, r_mag[15:0]});
                        w_mul_b = $signed({{(MW-28){1'b0}}, gqy_pkg::RAD90_Q32});
                    end
                    default: ;
                endcase
            end
            gqy_pkg::S_EULER: begin
                if (r_cnt < 6'd12) begin
                    w_mul_a = MW'(r_q[w_term_iss.qi]);
                    w_mul_b = MW'(r_h[w_term_iss.hi]);
                end
            end
            gqy_pkg::S_NORM: begin
                if (r_cnt < 6'd4) begin
                    w_mul_a = r_n[r_cnt[1:0]][34:2];
                    w_mul_b = r_n[r_cnt[1:0]][34:2];
                end
            end
            gqy_pkg::S_YAW: begin
                case (r_cnt)
                    6'd0: begin w_mul_a = MW'(r_q[0]); w_mul_b = MW'(r_q[0]); end
                    6'd1: begin w_mul_a = MW'(r_q[1]); w_mul_b = MW'(r_q[1]); end
                    6'd2: begin w_mul_a = MW'(r_q[2]); w_mul_b = MW'(r_q[2]); end
                    6'd3: begin w_mul_a = MW'(r_q[3]); w_mul_b = MW'(r_q[3]); end
                    6'd4: begin w_mul_a = MW'(r_q[1]); w_mul_b = MW'(r_q[2]); end
                    6'd5: begin w_mul_a = MW'(r_q[0]); w_mul_b = MW'(r_q[3]); end
                    default: ;
                endcase
            end
            gqy_pkg::S_HEAD: begin
                w_mul_a = w_ang;
                w_mul_b = $signed({{(MW-16){1'b0}}, gqy_pkg::CENTIDEG_TURN});
            end
            default: ;
        endcase
    end

    // Control state, configuration and attitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gqy_pkg::S_IDLE;
            r_cnt     <= '0;
            r_axis    <= '0;
            r_o_valid <= 1'b0;
            r_bias[0] <= '0;
            r_bias[1] <= '0;
            r_bias[2] <= '0;
            r_step    <= gqy_pkg::STEP_TIME_RST;
            r_q[0]    <= gqy_pkg::ONE_Q30;
            r_q[1]    <= '0;
            r_q[2]    <= '0;
            r_q[3]    <= '0;
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gqy_pkg::CFG_BIAS_X:    r_bias[0] <= i_cfg_data[15:0];
                    gqy_pkg::CFG_BIAS_Y:    r_bias[1] <= i_cfg_data[15:0];
                    gqy_pkg::CFG_BIAS_Z:    r_bias[2] <= i_cfg_data[15:0];
                    gqy_pkg::CFG_STEP_TIME: r_step    <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop a taken result, load a finished one
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            // Advance the step counter and the axis
            case (r_state)
                gqy_pkg::S_IDLE: begin
                    r_cnt  <= '0;
                    r_axis <= '0;
                end
                gqy_pkg::S_HALF: begin
                    if (r_cnt == 6'd4) begin
                        r_cnt  <= '0;
                        r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                gqy_pkg::S_DIV: begin
                    if (r_cnt == 6'd0 && r_axis == 2'd0 && r_s == 32'd0) begin
                        r_cnt  <= '0;
                        r_q[0] <= gqy_pkg::ONE_Q30;
                        r_q[1] <= '0;
                        r_q[2] <= '0;
                        r_q[3] <= '0;
                    end else if (r_cnt == 6'd31) begin
                        r_cnt       <= '0;
                        r_axis      <= r_axis + 2'd1;
                        r_q[r_axis] <= w_qval;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                default: begin
                    r_cnt <= (n_state != r_state) ? 6'd0 : r_cnt + 6'd1;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            gqy_pkg::S_IDLE: begin
                r_d[0] <= 17'(i_in.rate_x) - 17'(r_bias[0]);
                r_d[1] <= 17'(i_in.rate_y) - 17'(r_bias[1]);
                r_d[2] <= 17'(i_in.rate_z) - 17'(r_bias[2]);
            end
            gqy_pkg::S_HALF: begin
                case (r_cnt)
                    6'd1: begin
                        r_neg <= w_prod[40];
                        r_mag <= w_prod[40] ? 40'(-w_prod[40:0]) : w_prod[39:0];
                    end
                    6'd3: r_hic <= w_prod[51:0];
                    6'd4: begin
                        r_h[r_axis] <= w_h;
                        if (r_axis == 2'd2) begin
                            r_n[0] <= 35'(r_q[0]);
                            r_n[1] <= 35'(r_q[1]);
                            r_n[2] <= 35'(r_q[2]);
                            r_n[3] <= 35'(r_q[3]);
                        end
                    end
                    default: ;
                endcase
            end
            gqy_pkg::S_EULER: begin
                // Add or subtract the product of the previous term
                if (r_cnt != 6'd0) begin
                    if (w_term_acc.neg) begin
                        r_n[w_term_acc.comp] <= r_n[w_term_acc.comp] - w_prod[64:30];
                    end else begin
                        r_n[w_term_acc.comp] <= r_n[w_term_acc.comp] + w_prod[64:30];
                    end
                end
                r_sum <= '0;
            end
            gqy_pkg::S_NORM: begin
                if (r_cnt != 6'd0) begin
                    r_sum <= r_sum + w_prod[63:0];
                end
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            gqy_pkg::S_SQRT: begin
                if (w_sq_ge) begin
                    r_sum <= r_sum - w_trial;
                end
                r_res <= w_res_next;
                r_bit <= r_bit >> 2;
                if (r_cnt == 6'd31) begin
                    r_s <= w_res_next[31:0];
                end
            end
            gqy_pkg::S_DIV: begin
                if (r_cnt == 6'd0) begin
                    r_ovf <= {1'b0, w_dnum[61:31]} >= r_s;
                    r_rem <= {1'b0, w_dnum[61:31]};
                    r_num <= w_dnum[30:0];
                end else begin
                    r_rem <= w_dge ? 32'(w_dtry - {1'b0, r_s}) : w_dtry[31:0];
                    r_num <= r_num << 1;
                    r_quo <= w_fquo;
                end
                r_accx <= '0;
                r_accy <= '0;
            end
            gqy_pkg::S_YAW: begin
                case (r_cnt)
                    6'd1, 6'd2: r_accx <= r_accx + w_prod[63:0];
                    6'd3, 6'd4: r_accx <= r_accx - w_prod[63:0];
                    6'd5, 6'd6: r_accy <= r_accy + w_prod[63:0];
                    6'd7: begin
                        // Fold into the right half plane
                        r_zero <= (w_yx == 36'sd0) && (w_yy == 36'sd0);
                        if (w_yx < 0) begin
                            r_cx <= -w_yx;
                            r_cy <= -w_yy;
                            r_z  <= 32'h8000_0000;
                        end else begin
                            r_cx <= w_yx;
                            r_cy <= w_yy;
                            r_z  <= 32'd0;
                        end
                    end
                    default: ;
                endcase
            end
            gqy_pkg::S_CORDIC: begin
                if (r_cy < 0) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_z  <= r_z - w_atan;
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_z  <= r_z + w_atan;
                end
            end
            gqy_pkg::S_HEAD: begin
                if (r_cnt == 6'd1) begin
                    r_hd <= -$signed(w_hsum[47:32]);
                end
            end
            default: ;
        endcase

        // Hold the result until it is taken
        if (w_load) begin
            r_o_head <= r_hd;
            r_o_q[0] <= r_q[0];
            r_o_q[1] <= r_q[1];
            r_o_q[2] <= r_q[2];
            r_o_q[3] <= r_q[3];
        end
    end

    assign o_out.valid   = r_o_valid;
    assign o_out.heading = r_o_head;
    assign o_out.quat_w  = r_o_q[0];
    assign o_out.quat_x  = r_o_q[1];
    assign o_out.quat_y  = r_o_q[2];
    assign o_out.quat_z  = r_o_q[3];

endmodule

// ----- design/gqy_checker.sv -----
// Port-level checks for the gyro quaternion yaw block, bound to the top level.
module gqy_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_heading,
    input logic signed [31:0] i_quat_w
);

    // A result waiting for the receiver stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its heading and scalar part
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_heading) && $stable(i_quat_w))
        else $error("result changed while stalled");

    // The block is busy right after it takes an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready again right after accept");

    // Heading stays within half a turn
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_heading <= 16'sd18000) && (i_heading >= -16'sd18000))
        else $error("heading out of range");

    // Normalized scalar part stays within one
    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_quat_w <= 32'sh4000_0000) && (i_quat_w >= -32'sh4000_0000))
        else $error("quaternion scalar out of range");

endmodule

bind gyro_quaternion_yaw gqy_checker u_gqy_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_heading   (o_out.heading),
    .i_quat_w    (o_out.quat_w)
);
